FILE: design/sed_pkg.sv
// Shared constants, types and helpers for the string escape decoder.
// Used by the stream interface, the decoder top level and its checker.
// No dependencies.
package sed_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned SLOTS   = 3;
  localparam int unsigned CNT_W   = 2;

  // Quote modes; any code other than these follows the other-quote rules
  localparam logic [MODE_W-1:0] MODE_SINGLE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DOUBLE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RESET  = MODE_DOUBLE;

  localparam logic [BYTE_W-1:0] CH_BSL    = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_SQUOTE = 8'h27;
  localparam logic [BYTE_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [BYTE_W-1:0] CH_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CH_N      = 8'h6E;
  localparam logic [BYTE_W-1:0] CH_T      = 8'h74;
  localparam logic [BYTE_W-1:0] CH_R      = 8'h72;
  localparam logic [BYTE_W-1:0] CH_V      = 8'h76;
  localparam logic [BYTE_W-1:0] CH_F      = 8'h66;
  localparam logic [BYTE_W-1:0] CH_LX     = 8'h78;
  localparam logic [BYTE_W-1:0] CH_UX     = 8'h58;
  localparam logic [BYTE_W-1:0] CH_ZERO   = 8'h30;
  localparam logic [BYTE_W-1:0] CH_SEVEN  = 8'h37;

  localparam logic [BYTE_W-1:0] CODE_LF = 8'd10;
  localparam logic [BYTE_W-1:0] CODE_HT = 8'd9;
  localparam logic [BYTE_W-1:0] CODE_CR = 8'd13;
  localparam logic [BYTE_W-1:0] CODE_VT = 8'd11;
  localparam logic [BYTE_W-1:0] CODE_FF = 8'd12;

  typedef enum logic [4:0] {
    PH_NORMAL  = 5'b00001,
    PH_BSLASH  = 5'b00010,
    PH_HEXWAIT = 5'b00100,
    PH_HEXONE  = 5'b01000,
    PH_OCTAL   = 5'b10000
  } phase_t;

  // {valid, value} of a hex digit character
  function automatic logic [4:0] hex_digit(input logic [BYTE_W-1:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b1, b[3:0]};
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r = {1'b1, b[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic logic is_octal(input logic [BYTE_W-1:0] b);
    return (b >= CH_ZERO) && (b <= CH_SEVEN);
  endfunction

endpackage

FILE: design/sed_stream_if.sv
// Valid/ready byte stream channel with a last marker.
// Depends on sed_pkg for the byte width.
interface sed_stream_if;
  logic                           valid;
  logic                           ready;
  logic [sed_pkg::BYTE_W-1:0]     data_byte;
  logic                           last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

FILE: design/string_escape_decoder.sv
// String literal escape decoder: raw literal bytes in, unescaped bytes out.
// Depends on sed_pkg and sed_stream_if.
//
// Usage:
//   in_ch  carries one raw byte of a literal body per transfer; last marks
//          the final byte of the literal.
//   out_ch carries one decoded byte per transfer; last marks the final
//          decoded byte of the literal.
//   cfg_wr_en/cfg_wr_data write quote_mode (0 single, 1 double, else other
//          quote). Write it only while the block is idle.
// Latency: the decoded bytes of an input byte appear on out_ch in the
// cycle after its transfer. An input byte gives zero to three output bytes.
// Throughput: one input byte per cycle while each byte gives at most one
// output byte and out_ch is not stalled; a byte that gives k outputs holds
// the three-entry result buffer while out_ch drains it, one byte per ready cycle.
// in_ch.ready is high when the result buffer is empty or its single byte
// is being taken this cycle. When the receiver stalls, the buffer holds
// and input stops once it holds a byte.
// Reset clears the escape state and the result buffer, and sets quote_mode
// to double-quoted rules.
module string_escape_decoder (
  input  logic                         clk,
  input  logic                         rst_n,
  sed_stream_if.sink                   in_ch,
  sed_stream_if.source                 out_ch,
  input  logic                         cfg_wr_en,
  input  logic [sed_pkg::MODE_W-1:0]   cfg_wr_data
);

  logic [sed_pkg::MODE_W-1:0] quote_mode_r;
  sed_pkg::phase_t            phase_r, phase_nxt;
  logic [sed_pkg::BYTE_W-1:0] digit_r, digit_nxt;
  logic [1:0]                 dcount_r, dcount_nxt;
  logic [sed_pkg::BYTE_W-1:0] letter_r, letter_nxt;

  logic [sed_pkg::BYTE_W-1:0] slot_byte_r [sed_pkg::SLOTS];
  logic                       slot_last_r [sed_pkg::SLOTS];
  logic [sed_pkg::CNT_W-1:0]  cnt_r;

  logic [sed_pkg::BYTE_W-1:0] res_byte [sed_pkg::SLOTS];
  logic [sed_pkg::CNT_W-1:0]  res_n;

  logic                       take, pop;
  logic [sed_pkg::BYTE_W-1:0] b;
  logic [4:0]                 hx;

  assign b    = in_ch.data_byte;
  assign hx   = sed_pkg::hex_digit(b);
  assign pop  = out_ch.valid && out_ch.ready;
  assign take = in_ch.valid && in_ch.ready;

  assign in_ch.ready     = (cnt_r == '0) || ((cnt_r == 2'd1) && out_ch.ready);
  assign out_ch.valid    = (cnt_r != '0);
  assign out_ch.data_byte = slot_byte_r[0];
  assign out_ch.last     = slot_last_r[0];

  // Decode one byte: next escape state and the bytes it releases
  always_comb begin
    phase_nxt  = phase_r;
    digit_nxt  = digit_r;
    dcount_nxt = dcount_r;
    letter_nxt = letter_r;
    res_n      = '0;
    for (int i = 0; i < sed_pkg::SLOTS; i++) begin
      res_byte[i] = '0;
    end

    unique case (phase_r)
      sed_pkg::PH_BSLASH: begin
        phase_nxt = sed_pkg::PH_NORMAL;
        if (quote_mode_r == sed_pkg::MODE_SINGLE) begin
          if (b == sed_pkg::CH_BSL || b == sed_pkg::CH_SQUOTE) begin
            res_byte[res_n] = b; res_n = res_n + 2'd1;
          end else begin
            res_byte[res_n] = sed_pkg::CH_BSL; res_n = res_n + 2'd1;
            res_byte[res_n] = b; res_n = res_n + 2'd1;
          end
        end else begin
          case (b) inside
            sed_pkg::CH_N: begin res_byte[res_n] = sed_pkg::CODE_LF; res_n = res_n + 2'd1; end
            sed_pkg::CH_T: begin res_byte[res_n] = sed_pkg::CODE_HT; res_n = res_n + 2'd1; end
            sed_pkg::CH_R: begin res_byte[res_n] = sed_pkg::CODE_CR; res_n = res_n + 2'd1; end
            sed_pkg::CH_V: begin res_byte[res_n] = sed_pkg::CODE_VT; res_n = res_n + 2'd1; end
            sed_pkg::CH_F: begin res_byte[res_n] = sed_pkg::CODE_FF; res_n = res_n + 2'd1; end
            sed_pkg::CH_BSL, sed_pkg::CH_DOLLAR: begin
              res_byte[res_n] = b; res_n = res_n + 2'd1;
            end
            sed_pkg::CH_DQUOTE: begin
              if (quote_mode_r != sed_pkg::MODE_DOUBLE) begin
                res_byte[res_n] = sed_pkg::CH_BSL; res_n = res_n + 2'd1;
              end
              res_byte[res_n] = sed_pkg::CH_DQUOTE; res_n = res_n + 2'd1;
            end
            sed_pkg::CH_LX, sed_pkg::CH_UX: begin
              phase_nxt  = sed_pkg::PH_HEXWAIT;
              letter_nxt = b;
            end
            default: begin
              if (sed_pkg::is_octal(b)) begin
                phase_nxt  = sed_pkg::PH_OCTAL;
                digit_nxt  = {5'd0, b[2:0]};
                dcount_nxt = 2'd1;
              end else begin
                res_byte[res_n] = sed_pkg::CH_BSL; res_n = res_n + 2'd1;
                res_byte[res_n] = b; res_n = res_n + 2'd1;
              end
            end
          endcase
        end
      end
      sed_pkg::PH_HEXWAIT: begin
        if (hx[4]) begin
          digit_nxt = {4'd0, hx[3:0]};
          phase_nxt = sed_pkg::PH_HEXONE;
        end else begin
          res_byte[res_n] = sed_pkg::CH_BSL; res_n = res_n + 2'd1;
          res_byte[res_n] = letter_r; res_n = res_n + 2'd1;
          digit_nxt = '0; dcount_nxt = '0; letter_nxt = '0;
          if (b == sed_pkg::CH_BSL) begin
            phase_nxt = sed_pkg::PH_BSLASH;
          end else begin
            phase_nxt = sed_pkg::PH_NORMAL;
            res_byte[res_n] = b; res_n = res_n + 2'd1;
          end
        end
      end
      sed_pkg::PH_HEXONE: begin
        digit_nxt = '0; dcount_nxt = '0; letter_nxt = '0;
        phase_nxt = sed_pkg::PH_NORMAL;
        if (hx[4]) begin
          res_byte[res_n] = {digit_r[3:0], hx[3:0]}; res_n = res_n + 2'd1;
        end else begin
          res_byte[res_n] = digit_r; res_n = res_n + 2'd1;
          if (b == sed_pkg::CH_BSL) begin
            phase_nxt = sed_pkg::PH_BSLASH;
          end else begin
            res_byte[res_n] = b; res_n = res_n + 2'd1;
          end
        end
      end
      sed_pkg::PH_OCTAL: begin
        if (sed_pkg::is_octal(b)) begin
          digit_nxt  = {digit_r[4:0], b[2:0]};
          dcount_nxt = dcount_r + 2'd1;
          if (dcount_nxt == 2'd3) begin
            res_byte[res_n] = digit_nxt; res_n = res_n + 2'd1;
            phase_nxt = sed_pkg::PH_NORMAL;
            digit_nxt = '0; dcount_nxt = '0; letter_nxt = '0;
          end
        end else begin
          res_byte[res_n] = digit_r; res_n = res_n + 2'd1;
          digit_nxt = '0; dcount_nxt = '0; letter_nxt = '0;
          if (b == sed_pkg::CH_BSL) begin
            phase_nxt = sed_pkg::PH_BSLASH;
          end else begin
            phase_nxt = sed_pkg::PH_NORMAL;
            res_byte[res_n] = b; res_n = res_n + 2'd1;
          end
        end
      end
      default: begin
        digit_nxt = '0; dcount_nxt = '0; letter_nxt = '0;
        if (b == sed_pkg::CH_BSL) begin
          phase_nxt = sed_pkg::PH_BSLASH;
        end else begin
          phase_nxt = sed_pkg::PH_NORMAL;
          res_byte[res_n] = b; res_n = res_n + 2'd1;
        end
      end
    endcase

    // End of literal: flush whatever escape is still open
    if (in_ch.last) begin
      unique case (phase_nxt) inside
        sed_pkg::PH_BSLASH: begin
          res_byte[res_n] = sed_pkg::CH_BSL; res_n = res_n + 2'd1;
        end
        sed_pkg::PH_HEXWAIT: begin
          res_byte[res_n] = sed_pkg::CH_BSL; res_n = res_n + 2'd1;
          res_byte[res_n] = letter_nxt; res_n = res_n + 2'd1;
        end
        sed_pkg::PH_HEXONE, sed_pkg::PH_OCTAL: begin
          res_byte[res_n] = digit_nxt; res_n = res_n + 2'd1;
        end
        default: begin
        end
      endcase
      phase_nxt  = sed_pkg::PH_NORMAL;
      digit_nxt  = '0;
      dcount_nxt = '0;
      letter_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quote_mode_r <= sed_pkg::MODE_RESET;
      phase_r      <= sed_pkg::PH_NORMAL;
      digit_r      <= '0;
      dcount_r     <= '0;
      letter_r     <= '0;
    end else begin
      if (cfg_wr_en) begin
        quote_mode_r <= cfg_wr_data;
      end
      if (take) begin
        phase_r  <= phase_nxt;
        digit_r  <= digit_nxt;
        dcount_r <= dcount_nxt;
        letter_r <= letter_nxt;
      end
    end
  end

  // Result buffer: slot 0 is the head; a transfer only lands when it drains
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (take) begin
      cnt_r <= res_n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      for (int i = 0; i < sed_pkg::SLOTS; i++) begin
        slot_byte_r[i] <= res_byte[i];
        slot_last_r[i] <= in_ch.last && (res_n == sed_pkg::CNT_W'(i + 1));
      end
    end else if (pop) begin
      for (int i = 0; i < sed_pkg::SLOTS - 1; i++) begin
        slot_byte_r[i] <= slot_byte_r[i+1];
        slot_last_r[i] <= slot_last_r[i+1];
      end
    end
  end

endmodule

FILE: design/sed_checker.sv
// Port-level checks for string_escape_decoder, bound to the top level.
// Depends on sed_pkg for the byte width and on sed_stream_if through the bound ports.
module sed_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       in_last,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [sed_pkg::BYTE_W-1:0] out_data
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  // Input backpressure only while results are pending
  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with an empty result buffer");

  // A final byte always releases at least one result
  a_last_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("end of literal produced no result");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind string_escape_decoder sed_checker u_sed_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_data  (out_ch.data_byte)
);
